// ===== src/modular_exponentiation_defines.svh =====
// Assertion macros for the modular exponentiation port-level checker.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MODEXP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modexp assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MODEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modexp assertion failed");

`endif

// ===== src/modexp_pkg.sv =====
// Shared constants for the modular exponentiation block.
`default_nettype none

package modexp_pkg;

    // Width of the message, result and configuration fields.
    localparam int FIELD_BITS = 32;

    // Configuration register index port width and register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 2'd1;

endpackage

`default_nettype wire

// ===== src/modexp_if.sv =====
// Valid/ready channel interfaces for the message input and the result output.
`default_nettype none

interface modexp_msg_if;
    logic                             valid;
    logic                             ready;
    logic [modexp_pkg::FIELD_BITS-1:0] message;

    modport source (output valid, output message, input ready);
    modport sink   (input valid, input message, output ready);
endinterface

interface modexp_res_if;
    logic                             valid;
    logic                             ready;
    logic [modexp_pkg::FIELD_BITS-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// ===== src/modexp_modmul.sv =====
// Bit-serial interleaved modular multiplier: p = a * b mod n, one bit of a per cycle.
`default_nettype none

module modexp_modmul #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic [W-1:0] n,
    output logic              done,
    output logic [W-1:0]      p
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  a_sh_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  n_reg;
    logic [W-1:0]  p_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W+1:0]  t;
    logic [W+2:0]  d1;
    logic [W+2:0]  d2;
    logic [W-1:0]  p_next;

    // With p < n and b < n the doubled partial sum plus b stays below 3n,
    // so at most two subtractions of n bring it back into range.
    always_comb
    begin
        t  = {1'b0, p_reg, 1'b0} + (a_sh_reg[W-1] ? {2'b00, b_reg} : {(W+2){1'b0}});
        d1 = {1'b0, t} - {3'b000, n_reg};
        d2 = {1'b0, t} - {2'b00, n_reg, 1'b0};
        if (!d2[W+2])
        begin
            p_next = d2[W-1:0];
        end
        else if (!d1[W+2])
        begin
            p_next = d1[W-1:0];
        end
        else
        begin
            p_next = t[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_sh_reg <= a;
            b_reg    <= b;
            n_reg    <= n;
            p_reg    <= '0;
        end
        else if (busy_reg)
        begin
            a_sh_reg <= {a_sh_reg[W-2:0], 1'b0};
            p_reg    <= p_next;
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

`default_nettype wire

// ===== src/modular_exponentiation.sv =====
// Modular exponentiation top level: result = message^exponent mod modulus.
//
// Each message is raised by left-to-right square-and-multiply over all OPERAND_BITS exponent
// bits, with every modular product formed by one bit-serial multiplier. A transaction costs
// one base reduction plus one squaring per exponent bit and one extra product per set bit,
// so at most 2*OPERAND_BITS + 1 products, fewer for sparse exponents; when the modulus is
// zero no product is formed and the result is 0. One message is in work at a time; the
// result sits in an output register, so the next message is taken while it waits. Exponent
// and modulus reset to 1 and should be written only while the block is idle.
`default_nettype none

module modular_exponentiation #(
    parameter int OPERAND_BITS = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [modexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [modexp_pkg::FIELD_BITS-1:0]     cfg_data,
    modexp_msg_if.sink                                req,
    modexp_res_if.source                              rsp
);

    localparam int W   = OPERAND_BITS;
    localparam int BIW = $clog2(W);
    localparam logic [BIW-1:0] TOP_BIT = BIW'(W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_SQR,
        ST_MUL,
        ST_FINISH
    } state_t;

    state_t                             state_reg;
    logic [modexp_pkg::FIELD_BITS-1:0]  exponent_reg;
    logic [modexp_pkg::FIELD_BITS-1:0]  modulus_reg;
    logic [W-1:0]                       acc_reg;
    logic [W-1:0]                       base_reg;
    logic [BIW-1:0]                     bit_cnt_reg;
    logic [W-1:0]                       mm_a_reg;
    logic [W-1:0]                       mm_b_reg;
    logic                               mm_start_reg;
    logic                               rsp_valid_reg;
    logic [modexp_pkg::FIELD_BITS-1:0]  result_reg;

    logic [W-1:0] e_w;
    logic [W-1:0] n_w;
    logic [W-1:0] one_mod;
    logic         mm_done;
    logic [W-1:0] mm_p;

    assign e_w     = exponent_reg[W-1:0];
    assign n_w     = modulus_reg[W-1:0];
    // 1 mod n is zero only for a modulus of one.
    assign one_mod = (n_w == W'(1)) ? '0 : W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= modexp_pkg::FIELD_BITS'(1);
            modulus_reg  <= modexp_pkg::FIELD_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                modexp_pkg::REG_EXPONENT: exponent_reg <= cfg_data;
                modexp_pkg::REG_MODULUS:  modulus_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    modexp_modmul #(
        .W (W)
    ) u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start_reg),
        .a     (mm_a_reg),
        .b     (mm_b_reg),
        .n     (n_w),
        .done  (mm_done),
        .p     (mm_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mm_start_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            result_reg    <= '0;
            acc_reg       <= '0;
            base_reg      <= '0;
            bit_cnt_reg   <= '0;
            mm_a_reg      <= '0;
            mm_b_reg      <= '0;
        end
        else
        begin
            mm_start_reg <= 1'b0;
            if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        bit_cnt_reg <= TOP_BIT;
                        mm_a_reg    <= req.message[W-1:0];
                        mm_b_reg    <= one_mod;
                        if (n_w == '0)
                        begin
                            acc_reg   <= '0;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            // Reduce the base as message * (1 mod n).
                            acc_reg      <= one_mod;
                            mm_start_reg <= 1'b1;
                            state_reg    <= ST_BASE;
                        end
                    end
                end

                ST_BASE:
                begin
                    if (mm_done)
                    begin
                        base_reg     <= mm_p;
                        mm_a_reg     <= acc_reg;
                        mm_b_reg     <= acc_reg;
                        mm_start_reg <= 1'b1;
                        state_reg    <= ST_SQR;
                    end
                end

                ST_SQR:
                begin
                    if (mm_done)
                    begin
                        acc_reg <= mm_p;
                        if (e_w[bit_cnt_reg])
                        begin
                            mm_a_reg     <= mm_p;
                            mm_b_reg     <= base_reg;
                            mm_start_reg <= 1'b1;
                            state_reg    <= ST_MUL;
                        end
                        else if (bit_cnt_reg == '0)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            bit_cnt_reg  <= bit_cnt_reg - BIW'(1);
                            mm_a_reg     <= mm_p;
                            mm_b_reg     <= mm_p;
                            mm_start_reg <= 1'b1;
                        end
                    end
                end

                ST_MUL:
                begin
                    if (mm_done)
                    begin
                        acc_reg <= mm_p;
                        if (bit_cnt_reg == '0)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            bit_cnt_reg  <= bit_cnt_reg - BIW'(1);
                            mm_a_reg     <= mm_p;
                            mm_b_reg     <= mm_p;
                            mm_start_reg <= 1'b1;
                            state_reg    <= ST_SQR;
                        end
                    end
                end

                ST_FINISH:
                begin
                    // Wait until the output register is free or being emptied.
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        result_reg    <= modexp_pkg::FIELD_BITS'(acc_reg);
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req.ready  = (state_reg == ST_IDLE);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.result = result_reg;

endmodule

`default_nettype wire

// ===== src/modexp_checker.sv =====
// Port-level checker for the modular exponentiation block, bound to its top level.
`default_nettype none

`include "modular_exponentiation_defines.svh"

module modexp_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 cfg_we,
    input wire logic [modexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input wire logic [modexp_pkg::FIELD_BITS-1:0]     cfg_data,
    input wire logic                                 req_valid,
    input wire logic                                 req_ready,
    input wire logic                                 rsp_valid,
    input wire logic                                 rsp_ready,
    input wire logic [modexp_pkg::FIELD_BITS-1:0]     rsp_result
);

    logic [modexp_pkg::FIELD_BITS-1:0] modulus_reg;

    // Track the modulus as written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= modexp_pkg::FIELD_BITS'(1);
        end
        else if (cfg_we && (cfg_index == modexp_pkg::REG_MODULUS))
        begin
            modulus_reg <= cfg_data;
        end
    end

    `MODEXP_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)
    `MODEXP_ASSERT_SAME(a_result_reduced, clk, rst_n, rsp_valid, (rsp_result < modulus_reg) || (rsp_result == '0))
    `MODEXP_ASSERT_NEXT(a_rsp_hold_valid, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `MODEXP_ASSERT_NEXT(a_rsp_hold_data, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_result))

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_result (rsp.result)
);

`default_nettype wire

// ===== sim/modexp_checker.sv =====
// Checker for the modular exponentiation block: predicts every result and compares it.
`default_nettype none

module modexp_scoreboard #(
    parameter int OPERAND_BITS = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [modexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [modexp_pkg::FIELD_BITS-1:0]     cfg_data,
    modexp_msg_if                                     req,
    modexp_res_if                                     rsp,
    output int                                        errors,
    output int                                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] OPERAND_MASK = (64'd1 << OPERAND_BITS) - 64'd1;

    logic [modexp_pkg::FIELD_BITS-1:0] key_exponent;
    logic [modexp_pkg::FIELD_BITS-1:0] key_modulus;
    logic [modexp_pkg::FIELD_BITS-1:0] expected_results[$];
    logic [modexp_pkg::FIELD_BITS-1:0] wanted;
    int                                mismatches;

    // Left-to-right square-and-multiply over every operand bit, with the base
    // reduced first so that each product stays below 2^64.
    function automatic logic [modexp_pkg::FIELD_BITS-1:0] power_mod(
        input logic [modexp_pkg::FIELD_BITS-1:0] base,
        input logic [modexp_pkg::FIELD_BITS-1:0] power,
        input logic [modexp_pkg::FIELD_BITS-1:0] modulus
    );
        logic [63:0] n;
        logic [63:0] e;
        logic [63:0] b;
        logic [63:0] acc;
        n = {32'd0, modulus} & OPERAND_MASK;
        e = {32'd0, power} & OPERAND_MASK;
        if (n == 64'd0)
        begin
            return '0;
        end
        b = ({32'd0, base} & OPERAND_MASK) % n;
        acc = 64'd1 % n;
        for (int bit_pos = OPERAND_BITS - 1; bit_pos >= 0; bit_pos--)
        begin
            acc = (acc * acc) % n;
            if (e[bit_pos])
            begin
                acc = (acc * b) % n;
            end
        end
        return acc[modexp_pkg::FIELD_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_exponent <= 32'd1;
            key_modulus  <= 32'd1;
            expected_results.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    modexp_pkg::REG_EXPONENT: key_exponent <= cfg_data;
                    modexp_pkg::REG_MODULUS:  key_modulus  <= cfg_data;
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                expected_results.push_back(power_mod(req.message, key_exponent, key_modulus));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%t: result %h arrived with no message outstanding",
                                 $realtime, rsp.result);
                    end
                end
                else
                begin
                    wanted = expected_results.pop_front();
                    if (rsp.result !== wanted)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%t: result mismatch, expected %h, actual %h",
                                     $realtime, wanted, rsp.result);
                        end
                    end
                end
            end
            errors  <= mismatches;
            pending <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== sim/modular_exponentiation_tb.sv =====
// Testbench top for the modular exponentiation block: stimulus, watchdog and verdict.
`default_nettype none

module modular_exponentiation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [modexp_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [modexp_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

    localparam int IDLE_LIMIT    = 12000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 28;

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  cfg_we;
    logic [modexp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [modexp_pkg::FIELD_BITS-1:0]     cfg_data;

    modexp_msg_if req_ch();
    modexp_res_if rsp_ch();

    int errors;
    int pending;
    int idle_cycles;

    // When set, the sender or the receiver runs without gaps for a whole phase.
    bit no_gaps;
    bit no_stalls;

    logic [modexp_pkg::FIELD_BITS-1:0] cur_modulus;

    modular_exponentiation uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    modexp_scoreboard checker_inst (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .errors    (errors),
        .pending   (pending)
    );

    always #10 clk = ~clk;

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [modexp_pkg::FIELD_BITS-1:0] draw_exponent();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 20);
            2: return (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
            3: return 32'd65537;
            default: return $urandom() & $urandom();
        endcase
    endfunction

    function automatic logic [modexp_pkg::FIELD_BITS-1:0] draw_modulus();
        case ($urandom_range(0, 9))
            0, 1: return $urandom() | 32'h8000_0000;
            2:    return $urandom_range(1, 1000);
            3:    return 32'd1 << $urandom_range(0, 31);
            4:    return $urandom_range(0, 1);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [modexp_pkg::FIELD_BITS-1:0] draw_message(
        input logic [modexp_pkg::FIELD_BITS-1:0] n
    );
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 3);
            1: return n - 32'd1 + $urandom_range(0, 2);
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
            3: return (n != 0) ? ($urandom() % n) : $urandom();
            default: return $urandom();
        endcase
    endfunction

    // Starts and ends at a falling edge; valid stays high if the next message
    // follows with no gap.
    task automatic send_message(input logic [modexp_pkg::FIELD_BITS-1:0] msg);
        int gap;
        req_ch.valid   <= 1'b1;
        req_ch.message <= msg;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        @(negedge clk);
        gap = draw_wait(no_gaps);
        if (gap > 0)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.message <= $urandom();
            repeat (gap) @(negedge clk);
        end
    endtask

    // Lets every outstanding transaction finish before the key changes.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [modexp_pkg::CFG_INDEX_BITS-1:0] index,
                                  input logic [modexp_pkg::FIELD_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_key(input logic [modexp_pkg::FIELD_BITS-1:0] e,
                           input logic [modexp_pkg::FIELD_BITS-1:0] n);
        drain();
        if ($urandom_range(0, 1))
        begin
            write_register(modexp_pkg::REG_EXPONENT, e);
            write_register(modexp_pkg::REG_MODULUS, n);
        end
        else
        begin
            write_register(modexp_pkg::REG_MODULUS, n);
            write_register(modexp_pkg::REG_EXPONENT, e);
        end
        cur_modulus = n;
    endtask

    // Receiver: draws a stall before every result.
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_wait(no_stalls);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
            @(negedge clk);
        end
    end

    // Watchdog on cycles without any transaction on either channel.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("modular_exponentiation_tb: done, errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = modexp_pkg::REG_EXPONENT;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.message = '0;
        no_gaps        = 1'b0;
        no_stalls      = 1'b0;
        cur_modulus    = 32'd1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset key: modulus one, so everything reduces to zero.
        send_message(32'd0);
        send_message(32'hFFFF_FFFF);

        // Exponent zero gives one, or zero under modulus one.
        set_key(32'd0, 32'hFFFF_FFFF);
        send_message(32'd0);
        send_message(32'hFFFF_FFFF);
        send_message(32'd5);
        set_key(32'd0, 32'd1);
        send_message(32'd7);

        // Modulus zero has no meaning and yields zero.
        set_key(32'd5, 32'd0);
        send_message(32'd3);
        send_message(32'hFFFF_FFFF);

        // All exponent bits set, largest modulus, bases at and beside it.
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_message(32'hFFFF_FFFE);
        send_message(32'hFFFF_FFFF);
        send_message(32'd2);
        send_message(32'd1);

        // Small textbook key; writes past the last register must be ignored.
        set_key(32'd17, 32'd3233);
        write_register(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_register(REG_SPARE_HI, $urandom());
        send_message(32'd65);
        send_message(32'd3232);
        send_message(32'd3233);
        send_message(32'd3234);
        send_message(32'h8000_0000);
        set_key(32'd2753, 32'd3233);
        send_message(32'd2790);

        set_key(32'd1, 32'h8000_0000);
        send_message(32'hFFFF_FFFF);
        send_message(32'h7FFF_FFFF);
        set_key(32'h8000_0000, 32'hFFFF_FFFB);
        send_message(32'd3);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_key(draw_exponent(), draw_modulus());
            if ($urandom_range(0, 3) == 0)
            begin
                write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
            end
            no_gaps   = ($urandom_range(0, 3) == 0);
            no_stalls = ($urandom_range(0, 3) == 0);
            for (int item = 0; item < PHASE_ITEMS; item++)
            begin
                send_message(draw_message(cur_modulus));
            end
        end

        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("modular_exponentiation_tb: done, clean");
        end
        else
        begin
            $display("modular_exponentiation_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== modular_exponentiation.f =====
+incdir+src
src/modexp_pkg.sv
src/modexp_if.sv
src/modexp_modmul.sv
src/modular_exponentiation.sv
src/modexp_checker.sv
sim/modexp_checker.sv
sim/modular_exponentiation_tb.sv
